@@ design/skht_pkg.sv @@
// Package for the string-key hash table: field widths, operation codes and
// the command/status structs passed between the controller and datapath.
// No dependencies.
package skht_pkg;

    // Fixed field widths
    localparam int OP_W   = 2;
    localparam int KEY_W  = 64;
    localparam int VAL_W  = 32;
    localparam int CAP_W  = 9;
    localparam int CNT_W  = 9;
    localparam int HASH_W = 32;

    // Stream payload widths (byte aligned)
    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 48;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Operation codes
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic clear;     // write an empty row at the sweep address
        logic load;      // capture a new input beat
        logic hash_step; // fold one key byte into the hash
        logic div_step;  // one restoring division step
        logic rd_en;     // read the addressed slot
        logic update;    // read-modify-write of the slot
        logic out_load;  // move the result into the output register
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic top_zero;   // current key byte is the terminator
        logic clear_last; // sweep is at the last slot
    } dp_status_t;

endpackage

@@ design/string_key_hash_table.sv @@
// The item time is set by the 32-step bit-serial modulo and the
// one-byte-a-cycle hash, which stops at the first zero key byte.
// No new input beat is taken until the result beat has been loaded.
// After reset a sweep empties the slot memory; no input beat is taken
// until it ends. Configuration writes are taken always.
module string_key_hash_table #(
    parameter int SLOT_COUNT = 256,
    parameter int KEY_BYTES  = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [skht_pkg::IN_TDATA_W-1:0]   s_tdata,  // key[63:0], value[95:64]
    input  logic [skht_pkg::OP_W-1:0]         s_tuser,  // operation[1:0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [skht_pkg::OUT_TDATA_W-1:0]  m_tdata,  // found[0], value_out[32:1],
                                                        // occupied_count[41:33], zero pad
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [skht_pkg::PADDR_W-1:0]      paddr,
    input  logic [skht_pkg::PDATA_W-1:0]      pwdata,
    output logic [skht_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);
    import skht_pkg::*;

    localparam int CAP_RESET = (SLOT_COUNT < 511) ? SLOT_COUNT : 511;

    dp_cmd_t          cmd;
    dp_status_t       status;
    logic [CAP_W-1:0] cap_reg;
    logic             cfg_wr;
    logic             cap_sel;

    // Configuration register: table capacity, decoded wherever paddr[2] is 0
    assign pready  = 1'b1;
    assign cap_sel = (paddr[PADDR_W-1] == 1'b0);
    assign cfg_wr  = psel && penable && pwrite && pready && cap_sel;
    assign prdata  = cap_sel ? PDATA_W'(cap_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= CAP_W'(CAP_RESET);
        else if (cfg_wr)
            cap_reg <= pwdata[CAP_W-1:0];
    end

    skht_ctrl #(
        .KEY_BYTES (KEY_BYTES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    skht_dpath #(
        .SLOT_COUNT (SLOT_COUNT),
        .KEY_BYTES  (KEY_BYTES)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .in_op    (s_tuser),
        .in_key   (s_tdata[KEY_W-1:0]),
        .in_value (s_tdata[KEY_W +: VAL_W]),
        .capacity (cap_reg),
        .out_data (m_tdata)
    );

endmodule

@@ design/skht_dpath.sv @@
// Datapath of the string-key hash table: key normalisation, shift-add hash,
// bit-serial modulo, slot memory and result registers.
// Depends on skht_pkg.
module skht_dpath #(
    parameter int SLOT_COUNT = 256,
    parameter int KEY_BYTES  = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  skht_pkg::dp_cmd_t                 cmd,
    output skht_pkg::dp_status_t              status,
    input  logic [skht_pkg::OP_W-1:0]         in_op,
    input  logic [skht_pkg::KEY_W-1:0]        in_key,
    input  logic [skht_pkg::VAL_W-1:0]        in_value,
    input  logic [skht_pkg::CAP_W-1:0]        capacity,
    output logic [skht_pkg::OUT_TDATA_W-1:0]  out_data
);
    import skht_pkg::*;

    localparam int KEY_BITS = 8 * KEY_BYTES;
    localparam int SLOT_W   = $clog2(SLOT_COUNT);
    localparam int ROW_W    = 1 + KEY_BITS + VAL_W;
    localparam int CAP_MAX  = (SLOT_COUNT < 511) ? SLOT_COUNT : 511;
    localparam int PAD_W    = OUT_TDATA_W - 1 - VAL_W - CNT_W;

    logic [OP_W-1:0]        op_reg;
    logic [KEY_BITS-1:0]    key_reg;
    logic [VAL_W-1:0]       val_reg;
    logic [KEY_BITS-1:0]    shift_reg;
    logic [HASH_W-1:0]      hash_reg;
    logic [CAP_W-1:0]       rem_reg;
    logic [CAP_W-1:0]       cap_reg;
    logic [ROW_W-1:0]       rd_row_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   found_reg;
    logic                   found_next;
    logic [VAL_W-1:0]       vout_reg;
    logic [VAL_W-1:0]       vout_next;
    logic [SLOT_W-1:0]      clr_addr_reg;
    logic [OUT_TDATA_W-1:0] tdata_reg;

    logic [KEY_BITS-1:0]    key_norm;
    logic [CAP_W-1:0]       cap_eff;
    logic [7:0]             top_byte;
    logic [HASH_W-1:0]      hash_add;
    logic [CAP_W:0]         rem_ext;
    logic [CAP_W:0]         rem_sub;
    logic [SLOT_W-1:0]      slot;

    logic                   rd_valid;
    logic [KEY_BITS-1:0]    rd_key;
    logic [VAL_W-1:0]       rd_val;
    logic                   hit;
    logic                   upd_wr;
    logic [ROW_W-1:0]       upd_row;
    logic                   wr_en;
    logic [SLOT_W-1:0]      wr_addr;
    logic [ROW_W-1:0]       wr_row;

    logic [ROW_W-1:0]       mem [SLOT_COUNT];

    // Keep key bytes up to the first zero byte, drop the rest
    always_comb
    begin
        logic       alive;
        logic [7:0] b;
        alive    = 1'b1;
        key_norm = '0;
        for (int i = 0; i < KEY_BYTES; i++)
        begin
            b     = in_key[KEY_W-1-8*i -: 8];
            alive = alive && (b != 8'd0);
            key_norm[KEY_BITS-1-8*i -: 8] = alive ? b : 8'd0;
        end
    end

    // Effective capacity: 0 acts as 1, clamp to the slot count (at most 511)
    always_comb
    begin
        if (capacity == '0)
            cap_eff = CAP_W'(1);
        else if (capacity > CAP_W'(CAP_MAX))
            cap_eff = CAP_W'(CAP_MAX);
        else
            cap_eff = capacity;
    end

    // Hash and division step logic
    assign top_byte = shift_reg[KEY_BITS-1 -: 8];
    assign hash_add = {hash_reg[HASH_W-6:0], 5'd0} + {{(HASH_W-8){1'b0}}, top_byte};
    assign rem_ext  = {rem_reg, hash_reg[HASH_W-1]};
    assign rem_sub  = rem_ext - {1'b0, cap_reg};
    assign slot     = SLOT_W'(rem_reg);

    assign status.top_zero   = (top_byte == 8'd0);
    assign status.clear_last = (clr_addr_reg == SLOT_W'(SLOT_COUNT - 1));

    // Input capture, hash and remainder registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= in_op;
            key_reg   <= key_norm;
            val_reg   <= in_value;
            shift_reg <= key_norm;
            hash_reg  <= '0;
            rem_reg   <= '0;
            cap_reg   <= cap_eff;
        end
        else if (cmd.hash_step)
        begin
            hash_reg  <= hash_add;
            shift_reg <= shift_reg << 8;
        end
        else if (cmd.div_step)
        begin
            hash_reg <= {hash_reg[HASH_W-2:0], 1'b0};
            if (rem_ext >= {1'b0, cap_reg})
                rem_reg <= rem_sub[CAP_W-1:0];
            else
                rem_reg <= rem_ext[CAP_W-1:0];
        end
    end

    // Fields of the row read back
    assign rd_valid = rd_row_reg[ROW_W-1];
    assign rd_key   = rd_row_reg[VAL_W +: KEY_BITS];
    assign rd_val   = rd_row_reg[VAL_W-1:0];
    assign hit      = rd_valid && (rd_key == key_reg);

    // Update decision for the addressed slot
    always_comb
    begin
        upd_wr     = 1'b0;
        upd_row    = '0;
        found_next = 1'b0;
        vout_next  = '0;
        count_next = count_reg;
        case (op_reg)
            OP_LOOKUP:
            begin
                found_next = hit;
                vout_next  = hit ? rd_val : '0;
            end
            OP_INSERT:
            begin
                upd_wr     = 1'b1;
                upd_row    = {1'b1, key_reg, val_reg};
                found_next = 1'b1;
                count_next = rd_valid ? count_reg : count_reg + CNT_W'(1);
            end
            OP_REMOVE:
            begin
                if (hit)
                begin
                    upd_wr     = 1'b1;
                    found_next = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                upd_wr = 1'b0;
            end
        endcase
    end

    // Write port shared by the clearing sweep and the update
    assign wr_en   = cmd.clear | (cmd.update & upd_wr);
    assign wr_addr = cmd.clear ? clr_addr_reg : slot;
    assign wr_row  = cmd.clear ? '0 : upd_row;

    // Slot memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_row;
        if (cmd.rd_en)
            rd_row_reg <= mem[slot];
    end

    // Fill count and sweep address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            clr_addr_reg <= '0;
        end
        else
        begin
            if (cmd.update)
                count_reg <= count_next;
            if (cmd.clear)
                clr_addr_reg <= clr_addr_reg + SLOT_W'(1);
        end
    end

    // Result and output registers
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            found_reg <= found_next;
            vout_reg  <= vout_next;
        end
        if (cmd.out_load)
            tdata_reg <= {{PAD_W{1'b0}}, count_reg, vout_reg, found_reg};
    end

    assign out_data = tdata_reg;

endmodule

@@ design/skht_ctrl.sv @@
// Controller of the string-key hash table: sequences the clearing sweep,
// hashing, modulo, slot read-modify-write and the output handshake.
// Depends on skht_pkg.
module skht_ctrl #(
    parameter int KEY_BYTES = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  skht_pkg::dp_status_t  status,
    output skht_pkg::dp_cmd_t     cmd
);
    import skht_pkg::*;

    localparam int BYTE_CNT_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
    localparam int BIT_CNT_W  = $clog2(HASH_W);

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_HASH   = 7'b0000100,
        ST_MOD    = 7'b0001000,
        ST_READ   = 7'b0010000,
        ST_UPDATE = 7'b0100000,
        ST_OUT    = 7'b1000000
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    logic [BYTE_CNT_W-1:0]  byte_cnt_reg;
    logic [BYTE_CNT_W-1:0]  byte_cnt_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg;
    logic [BIT_CNT_W-1:0]   bit_cnt_next;
    logic                   m_tvalid_reg;
    logic                   m_tvalid_next;
    logic                   out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        byte_cnt_next = byte_cnt_reg;
        bit_cnt_next  = bit_cnt_reg;
        cmd           = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load      = 1'b1;
                    byte_cnt_next = '0;
                    state_next    = ST_HASH;
                end
            end
            ST_HASH:
            begin
                bit_cnt_next = '0;
                if (status.top_zero)
                    state_next = ST_MOD;
                else
                begin
                    cmd.hash_step = 1'b1;
                    byte_cnt_next = byte_cnt_reg + BYTE_CNT_W'(1);
                    if (byte_cnt_reg == BYTE_CNT_W'(KEY_BYTES - 1))
                        state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                cmd.div_step = 1'b1;
                bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
                if (bit_cnt_reg == BIT_CNT_W'(HASH_W - 1))
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Output valid: set on load, cleared when the beat is taken
    always_comb
    begin
        if (cmd.out_load)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
        else
            m_tvalid_next = m_tvalid_reg;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            byte_cnt_reg <= '0;
            bit_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            byte_cnt_reg <= byte_cnt_next;
            bit_cnt_reg  <= bit_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

@@ design/skht_checker.sv @@
// Port-level checks for string_key_hash_table, attached by bind.
// Depends on skht_pkg.
module skht_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [skht_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input logic                              pready
);
    import skht_pkg::*;

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // One item at a time: no input beat right after one is taken
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken on consecutive cycles");

    // A miss never returns a value
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[VAL_W:1] == '0)
        else $error("value returned without a hit");

    // Configuration port never waits
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind string_key_hash_table skht_checker u_skht_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);
